// ===== design/tmco_pkg.sv =====
// Shared widths, reset values, register codes and control types for the clock offset estimator.
`timescale 1ns / 1ps
`default_nettype none
package tmco_pkg;

  localparam int TIME_W  = 40;  // local, client and server stamps
  localparam int PING_W  = 16;  // reported ping, milliseconds
  localparam int PM_W    = 26;  // ping converted to microseconds
  localparam int RTT_W   = 32;  // saturated round-trip time
  localparam int OFF_W   = 41;  // signed clock offset
  localparam int OFFX_W  = OFF_W + 1;  // offset with one guard bit for saturation
  localparam int THR_W   = 32;
  localparam int OUTL_W  = 5;
  localparam int STEP_W  = 6;   // counts serial steps up to OFFX_W

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam int IN_DATA_W  = 136;  // 3 x 40 + 16, already whole bytes
  localparam int OUT_DATA_W = 48;   // 41 bits padded to whole bytes

  localparam int DEF_WINDOW = 8;

  localparam logic [THR_W-1:0]  THR_RESET  = 32'd100000;
  localparam logic [OUTL_W-1:0] OUTL_RESET = 5'd1;

  localparam logic [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};
  localparam logic [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_PING_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIERS       = 1'd1;

  // Control of one bit-serial subtractor
  typedef struct packed {
    logic load;  // capture both operands, clear the borrow
    logic step;  // advance one bit
  } ser_ctrl_t;

endpackage
`default_nettype wire

// ===== design/tmco_serial_sub.sv =====
// Bit-serial subtractor: a - b over N bits, one bit per cycle while step is asserted, LSB first.
`timescale 1ns / 1ps
`default_nettype none
module tmco_serial_sub #(
  parameter int N = 40
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  tmco_pkg::ser_ctrl_t ctl_i,
  input  wire  [N-1:0]        a_i,
  input  wire  [N-1:0]        b_i,
  output logic [N-1:0]        diff_o,
  output logic                borrow_o
);

  logic [N-1:0] a_q, b_q, d_q;
  logic         br_q;
  logic         bit_d, br_d;

  assign bit_d = a_q[0] ^ b_q[0] ^ br_q;
  assign br_d  = (~a_q[0] & b_q[0]) | (~(a_q[0] ^ b_q[0]) & br_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      br_q <= 1'b0;
    end else if (ctl_i.load) begin
      br_q <= 1'b0;
    end else if (ctl_i.step) begin
      br_q <= br_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      a_q <= a_i;
      b_q <= b_i;
    end else if (ctl_i.step) begin
      a_q <= {1'b0, a_q[N-1:1]};
      b_q <= {1'b0, b_q[N-1:1]};
      d_q <= {bit_d, d_q[N-1:1]};
    end
  end

  assign diff_o   = d_q;
  assign borrow_o = br_q;

endmodule
`default_nettype wire

// ===== design/tmco_hist_mem.sv =====
// Round-trip history memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module tmco_hist_mem #(
  parameter int DEPTH = tmco_pkg::DEF_WINDOW,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire                         clk_i,
  input  wire                         we_i,
  input  wire  [AW-1:0]               waddr_i,
  input  wire  [tmco_pkg::RTT_W-1:0]  wdata_i,
  input  wire  [AW-1:0]               raddr_i,
  output logic [tmco_pkg::RTT_W-1:0]  rdata_o
);

  logic [tmco_pkg::RTT_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== design/tmco_rank.sv =====
// Trimmed sum: ranks each stored sample against all others and sums those inside the kept band.
`timescale 1ns / 1ps
`default_nettype none
module tmco_rank #(
  parameter int WINDOW = tmco_pkg::DEF_WINDOW,
  parameter int IDX_W  = $clog2(WINDOW),
  parameter int K_W    = $clog2(WINDOW + 1),
  parameter int SUM_W  = tmco_pkg::RTT_W + $clog2(WINDOW)
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  input  wire  [K_W-1:0]              k_i,
  output logic [IDX_W-1:0]            raddr_o,
  input  wire  [tmco_pkg::RTT_W-1:0]  rdata_i,
  output logic                        done_o,
  output logic [SUM_W-1:0]            sum_o
);

  typedef enum logic [2:0] {
    R_IDLE,
    R_ISSUE,
    R_GRAB,
    R_SCAN,
    R_ACC
  } rank_state_e;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);

  rank_state_e                state_q;
  logic [IDX_W-1:0]           i_q, j_q;
  logic [K_W-1:0]             rank_q;
  logic [tmco_pkg::RTT_W-1:0] vi_q;
  logic [K_W-1:0]             hi;
  logic                       less;

  assign hi = K_W'(WINDOW) - k_i;

  // Order by value, ties broken by slot so that every rank is distinct
  assign less = (rdata_i < vi_q) || ((rdata_i == vi_q) && (j_q < i_q));

  always_comb begin
    case (state_q)
      R_ISSUE: raddr_o = i_q;
      R_SCAN:  raddr_o = j_q + 1'b1;
      default: raddr_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_o  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      rank_q  <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        R_IDLE: begin
          if (start_i) begin
            i_q     <= '0;
            sum_o   <= '0;
            state_q <= R_ISSUE;
          end
        end
        R_ISSUE: begin
          state_q <= R_GRAB;
        end
        R_GRAB: begin
          vi_q    <= rdata_i;
          j_q     <= '0;
          rank_q  <= '0;
          state_q <= R_SCAN;
        end
        R_SCAN: begin
          rank_q <= rank_q + K_W'(less);
          if (j_q == LAST) begin
            state_q <= R_ACC;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        R_ACC: begin
          if (rank_q >= k_i && rank_q < hi) begin
            sum_o <= sum_o + SUM_W'(vi_q);
          end
          if (i_q == LAST) begin
            done_o  <= 1'b1;
            state_q <= R_IDLE;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= R_ISSUE;
          end
        end
        default: state_q <= R_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/tmco_div.sv =====
// Restoring divider: one quotient bit per cycle with a narrow remainder.
`timescale 1ns / 1ps
`default_nettype none
module tmco_div #(
  parameter int DVD_W = 35,
  parameter int DSR_W = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire  [DVD_W-1:0] dividend_i,
  input  wire  [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [DSR_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, quotient_o[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quotient_o <= dividend_i;
      dsr_q      <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      rem_q      <= ge ? DSR_W'(trial - {1'b0, dsr_q}) : trial[DSR_W-1:0];
      quotient_o <= {quotient_o[DVD_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ===== design/trimmed_mean_clock_offset.sv =====
// Top level of the trimmed-mean round-trip clock offset estimator.
// Sequence from the accepting edge to m_axis_tvalid: 40 serial subtract steps (S_SUB),
//   3 round-trip steps (S_SAT, S_AVG, S_STORE), the offset load (S_OFFLD), 42 offset steps
//   (S_OFF) and the hand-off (S_FIN); once the window is full, ranking (S_RANK) and division
//   (S_DIV) come between S_STORE and S_OFFLD.
// Throughput: one transaction in flight; the next is accepted once the result is handed off.
// Reset clears the sequencer, sample count, oldest slot and registers; history needs none.
`timescale 1ns / 1ps
`default_nettype none
module trimmed_mean_clock_offset #(
  parameter int WINDOW = tmco_pkg::DEF_WINDOW
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  // Input stream
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  // [39:0] local_now, [79:40] client_stamp, [119:80] server_stamp, [135:120] ping_ms
  input  wire  [tmco_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] ping_known
  input  wire  [0:0]                          s_axis_tuser,
  // Result stream
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  // [40:0] clock_offset (signed), [47:41] zero
  output logic [tmco_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // [0] used_trimmed_mean
  output logic [0:0]                          m_axis_tuser,
  // Configuration writes
  input  wire                                 cfg_we_i,
  input  wire  [tmco_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [tmco_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int TIME_W = tmco_pkg::TIME_W;
  localparam int RTT_W  = tmco_pkg::RTT_W;
  localparam int OFFX_W = tmco_pkg::OFFX_W;
  localparam int OFF_W  = tmco_pkg::OFF_W;
  localparam int PM_W   = tmco_pkg::PM_W;
  localparam int PING_W = tmco_pkg::PING_W;
  localparam int OUTL_W = tmco_pkg::OUTL_W;
  localparam int STEP_W = tmco_pkg::STEP_W;

  localparam int IDX_W = $clog2(WINDOW);
  localparam int K_W   = $clog2(WINDOW + 1);
  localparam int SUM_W = RTT_W + $clog2(WINDOW);
  localparam int KMAX  = (WINDOW - 1) / 2;

  localparam logic [IDX_W-1:0]  LAST_SLOT  = IDX_W'(WINDOW - 1);
  localparam logic [OUTL_W-1:0] KMAX_O     = OUTL_W'(KMAX);
  localparam logic [STEP_W-1:0] SUB_LAST   = STEP_W'(TIME_W - 1);
  localparam logic [STEP_W-1:0] OFF_LAST   = STEP_W'(OFFX_W - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB,
    S_SAT,
    S_AVG,
    S_STORE,
    S_RANK,
    S_DIV,
    S_OFFLD,
    S_OFF,
    S_FIN
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [tmco_pkg::THR_W-1:0] thr_q;
  logic [OUTL_W-1:0]          outl_q;

  // Per-transaction working registers
  logic [STEP_W-1:0] step_q;
  logic [PM_W-1:0]   pm_q;
  logic              pk_q;
  logic [RTT_W-1:0]  rtt_q;
  logic [RTT_W-1:0]  used_q;
  logic              full_q;

  // History bookkeeping
  logic [IDX_W-1:0] count_q;
  logic [IDX_W-1:0] oldest_q;

  logic accept;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Serial subtractors: round trip, server minus client, final offset
  tmco_pkg::ser_ctrl_t front_ctl, off_ctl;
  logic [TIME_W-1:0]   rt_diff, sc_diff;
  logic                rt_borrow, sc_borrow;
  logic [OFFX_W-1:0]   off_a, off_b, off_res;
  logic                off_borrow;

  always_comb begin
    front_ctl.load = accept;
    front_ctl.step = (state_q == S_SUB);
    off_ctl.load   = (state_q == S_OFFLD);
    off_ctl.step   = (state_q == S_OFF);
  end

  tmco_serial_sub #(.N(TIME_W)) u_rt_sub (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (front_ctl),
    .a_i      (s_axis_tdata[TIME_W-1:0]),
    .b_i      (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .diff_o   (rt_diff),
    .borrow_o (rt_borrow)
  );

  tmco_serial_sub #(.N(TIME_W)) u_sc_sub (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (front_ctl),
    .a_i      (s_axis_tdata[3*TIME_W-1:2*TIME_W]),
    .b_i      (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .diff_o   (sc_diff),
    .borrow_o (sc_borrow)
  );

  // Server minus client as a signed value, extended by a guard bit; minus half the round trip
  assign off_a = {sc_borrow, sc_borrow, sc_diff};
  assign off_b = {{(OFFX_W-RTT_W+1){1'b0}}, used_q[RTT_W-1:1]};

  tmco_serial_sub #(.N(OFFX_W)) u_off_sub (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (off_ctl),
    .a_i      (off_a),
    .b_i      (off_b),
    .diff_o   (off_res),
    .borrow_o (off_borrow)
  );

  // History memory and trimmed-sum engine
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [RTT_W-1:0] mem_rdata;
  logic [IDX_W:0]   slot_sum;

  assign slot_sum  = {1'b0, oldest_q} + {1'b0, count_q};
  assign mem_waddr = (slot_sum >= (IDX_W+1)'(WINDOW)) ?
                     IDX_W'(slot_sum - (IDX_W+1)'(WINDOW)) : slot_sum[IDX_W-1:0];
  assign mem_we    = (state_q == S_STORE);

  tmco_hist_mem #(.DEPTH(WINDOW), .AW(IDX_W)) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rtt_q),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Clamp the trim count so at least one sample survives
  logic [OUTL_W-1:0] k_clamped;
  logic [K_W-1:0]    k_trim, divisor;
  assign k_clamped = (outl_q > KMAX_O) ? KMAX_O : outl_q;
  assign k_trim    = K_W'(k_clamped);
  assign divisor   = K_W'(WINDOW) - {k_trim[K_W-2:0], 1'b0};

  logic             is_full;
  logic             rank_start, rank_done;
  logic [SUM_W-1:0] trim_sum;
  assign is_full    = (count_q == LAST_SLOT);
  assign rank_start = (state_q == S_STORE) && is_full;

  tmco_rank #(.WINDOW(WINDOW), .IDX_W(IDX_W), .K_W(K_W), .SUM_W(SUM_W)) u_rank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rank_start),
    .k_i     (k_trim),
    .raddr_o (mem_raddr),
    .rdata_i (mem_rdata),
    .done_o  (rank_done),
    .sum_o   (trim_sum)
  );

  logic             div_start, div_done;
  logic [SUM_W-1:0] quotient;
  assign div_start = (state_q == S_RANK) && rank_done;

  tmco_div #(.DVD_W(SUM_W), .DSR_W(K_W)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (trim_sum),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Ping in microseconds: ping * 1000 = ping * 1024 - ping * 16 - ping * 8
  logic [PING_W-1:0] ping;
  logic [PM_W-1:0]   ping_us;
  logic [RTT_W:0]    avg_sum;
  logic [RTT_W-1:0]  rtt_sat;
  logic [OFF_W-1:0]  off_sat;

  assign ping    = s_axis_tdata[3*TIME_W+PING_W-1:3*TIME_W];
  assign ping_us = {ping, 10'b0} - {6'b0, ping, 4'b0} - {7'b0, ping, 3'b0};
  assign avg_sum = {1'b0, rtt_q} + {{(RTT_W+1-PM_W){1'b0}}, pm_q};

  // Negative round trip clamps to zero, anything past 32 bits to all ones
  assign rtt_sat = rt_borrow ? '0 :
                   (|rt_diff[TIME_W-1:RTT_W]) ? '1 : rt_diff[RTT_W-1:0];

  // Offset leaves the 41-bit range only when the guard bit disagrees with the sign
  assign off_sat = (off_res[OFFX_W-1] == off_res[OFF_W-1]) ? off_res[OFF_W-1:0] :
                   (off_res[OFFX_W-1] ? tmco_pkg::OFF_MIN : tmco_pkg::OFF_MAX);

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      step_q        <= '0;
      count_q       <= '0;
      oldest_q      <= '0;
      thr_q         <= tmco_pkg::THR_RESET;
      outl_q        <= tmco_pkg::OUTL_RESET;
      m_axis_tvalid <= 1'b0;
      full_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          tmco_pkg::CFG_PING_THRESHOLD: thr_q  <= cfg_wdata_i[tmco_pkg::THR_W-1:0];
          tmco_pkg::CFG_OUTLIERS:       outl_q <= cfg_wdata_i[OUTL_W-1:0];
          default: ;
        endcase
      end

      // Drop the result once the consumer takes it; a new result loads it again in S_FIN
      if (m_axis_tvalid && m_axis_tready && state_q != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pm_q    <= ping_us;
            pk_q    <= s_axis_tuser[0];
            step_q  <= '0;
            state_q <= S_SUB;
          end
        end
        S_SUB: begin
          step_q <= step_q + 1'b1;
          if (step_q == SUB_LAST) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          rtt_q   <= rtt_sat;
          state_q <= S_AVG;
        end
        S_AVG: begin
          // Blend in the reported ping when it is known and the measured round trip is suspiciously long
          if (rtt_q > thr_q && pk_q) begin
            rtt_q <= avg_sum[RTT_W:1];
          end
          state_q <= S_STORE;
        end
        S_STORE: begin
          if (is_full) begin
            oldest_q <= (oldest_q == LAST_SLOT) ? '0 : oldest_q + 1'b1;
            full_q   <= 1'b1;
            state_q  <= S_RANK;
          end else begin
            count_q <= count_q + 1'b1;
            used_q  <= rtt_q;
            full_q  <= 1'b0;
            state_q <= S_OFFLD;
          end
        end
        S_RANK: begin
          if (rank_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            used_q  <= quotient[RTT_W-1:0];
            state_q <= S_OFFLD;
          end
        end
        S_OFFLD: begin
          step_q  <= '0;
          state_q <= S_OFF;
        end
        S_OFF: begin
          step_q <= step_q + 1'b1;
          if (step_q == OFF_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // Hold until the result register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {{(tmco_pkg::OUT_DATA_W-OFF_W){1'b0}}, off_sat};
            m_axis_tuser  <= full_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Final borrow of the offset subtract carries no information past the guard bit
  logic unused_borrow;
  assign unused_borrow = off_borrow;

endmodule
`default_nettype wire
